### sv/sl_pkg.sv
`default_nettype none

package sl_pkg;

  // Saturation widths of the position counters and of the length counter
  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 16;

  typedef logic [4:0] kind_t;

  localparam kind_t K_INT    = 5'd0;
  localparam kind_t K_FLOAT  = 5'd1;
  localparam kind_t K_IDENT  = 5'd2;
  localparam kind_t K_U32    = 5'd3;
  localparam kind_t K_STRING = 5'd4;
  localparam kind_t K_FUNC   = 5'd5;
  localparam kind_t K_IF     = 5'd6;
  localparam kind_t K_ELSE   = 5'd7;
  localparam kind_t K_VAR    = 5'd8;
  localparam kind_t K_CONST  = 5'd9;
  localparam kind_t K_RETURN = 5'd10;
  localparam kind_t K_EQEQ   = 5'd11;
  localparam kind_t K_OROR   = 5'd12;
  localparam kind_t K_ARROW  = 5'd13;
  localparam kind_t K_BAR    = 5'd14;
  localparam kind_t K_AMP    = 5'd15;
  localparam kind_t K_LPAREN = 5'd16;
  localparam kind_t K_RPAREN = 5'd17;
  localparam kind_t K_LBRACE = 5'd18;
  localparam kind_t K_RBRACE = 5'd19;
  localparam kind_t K_COLON  = 5'd20;
  localparam kind_t K_SEMI   = 5'd21;
  localparam kind_t K_COMMA  = 5'd22;
  localparam kind_t K_MINUS  = 5'd23;
  localparam kind_t K_PLUS   = 5'd24;
  localparam kind_t K_ASSIGN = 5'd25;
  localparam kind_t K_DOT    = 5'd26;
  localparam kind_t K_END    = 5'd27;
  localparam kind_t K_ERROR  = 5'd28;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } res_t;

  // Up to three results from one transaction, packed from slot zero
  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } push_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

### sv/sl_scan.sv
`default_nettype none

module sl_scan import sl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_flag,
  output push_t           push
);

  localparam int POS_W = POSITION_BITS;
  localparam int LEN_W = LENGTH_BITS;

  typedef enum logic [2:0] {
    PH_IDLE, PH_INT, PH_FRAC, PH_IDENT, PH_LINE, PH_BOPEN, PH_BLOCK, PH_SKIP
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  tline;
    logic [POS_W-1:0]  tcol;
    logic [LEN_W-1:0]  tlen;
    logic [63:0]       prefix;
    logic              halted;
  } st_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [31:0] line;
    logic [31:0] col;
    logic [31:0] len;
  } em_t;

  typedef struct packed {
    st_t st;
    em_t em;
  } cs_t;

  localparam kind_t      K_NONE   = 5'd0;
  localparam logic [8:0] NO_CHAR  = 9'h100;
  localparam logic [8:0] C_NL     = 9'h00A;
  localparam logic [8:0] C_SPACE  = 9'h020;
  localparam logic [8:0] C_SLASH  = 9'h02F;
  localparam logic [8:0] C_STAR   = 9'h02A;
  localparam logic [8:0] C_DOT    = 9'h02E;
  localparam logic [8:0] C_USCORE = 9'h05F;
  localparam logic [8:0] C_EQ     = 9'h03D;
  localparam logic [8:0] C_BAR    = 9'h07C;
  localparam logic [8:0] C_MINUS  = 9'h02D;
  localparam logic [8:0] C_GT     = 9'h03E;
  localparam logic [8:0] C_AMP    = 9'h026;
  localparam logic [8:0] C_LPAREN = 9'h028;
  localparam logic [8:0] C_RPAREN = 9'h029;
  localparam logic [8:0] C_LBRACE = 9'h07B;
  localparam logic [8:0] C_RBRACE = 9'h07D;
  localparam logic [8:0] C_COLON  = 9'h03A;
  localparam logic [8:0] C_SEMI   = 9'h03B;
  localparam logic [8:0] C_COMMA  = 9'h02C;
  localparam logic [8:0] C_PLUS   = 9'h02B;

  localparam logic [63:0] KW_U32    = 64'h0000_0000_0075_3332;
  localparam logic [63:0] KW_STRING = 64'h0000_7374_7269_6E67;
  localparam logic [63:0] KW_FUNC   = 64'h6675_6E63_7469_6F6E;
  localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6966;
  localparam logic [63:0] KW_ELSE   = 64'h0000_0000_656C_7365;
  localparam logic [63:0] KW_VAR    = 64'h0000_0000_0076_6172;
  localparam logic [63:0] KW_CONST  = 64'h0000_0063_6F6E_7374;
  localparam logic [63:0] KW_RETURN = 64'h0000_7265_7475_726E;

  function automatic logic is_digit(input logic [8:0] c);
    return (c >= 9'h030) && (c <= 9'h039);
  endfunction

  function automatic logic is_alpha(input logic [8:0] c);
    return ((c >= 9'h061) && (c <= 9'h07A)) || ((c >= 9'h041) && (c <= 9'h05A));
  endfunction

  function automatic logic is_space(input logic [8:0] c);
    return (c == C_SPACE) || ((c >= 9'h009) && (c <= 9'h00D));
  endfunction

  function automatic logic is_word(input logic [8:0] c);
    return is_alpha(c) || is_digit(c) || (c == C_USCORE);
  endfunction

  // {two-character flag, kind}; kind K_NONE where nothing matches
  function automatic logic [5:0] punct(input logic [8:0] c, input logic [8:0] n);
    logic [5:0] r;
    r = {1'b0, K_NONE};
    if (c == C_EQ && n == C_EQ)         r = {1'b1, K_EQEQ};
    else if (c == C_BAR && n == C_BAR)  r = {1'b1, K_OROR};
    else if (c == C_MINUS && n == C_GT) r = {1'b1, K_ARROW};
    else if (c == C_BAR)                r = {1'b0, K_BAR};
    else if (c == C_AMP)                r = {1'b0, K_AMP};
    else if (c == C_LPAREN)             r = {1'b0, K_LPAREN};
    else if (c == C_RPAREN)             r = {1'b0, K_RPAREN};
    else if (c == C_LBRACE)             r = {1'b0, K_LBRACE};
    else if (c == C_RBRACE)             r = {1'b0, K_RBRACE};
    else if (c == C_COLON)              r = {1'b0, K_COLON};
    else if (c == C_SEMI)               r = {1'b0, K_SEMI};
    else if (c == C_COMMA)              r = {1'b0, K_COMMA};
    else if (c == C_MINUS)              r = {1'b0, K_MINUS};
    else if (c == C_PLUS)               r = {1'b0, K_PLUS};
    else if (c == C_EQ)                 r = {1'b0, K_ASSIGN};
    else if (c == C_DOT)                r = {1'b0, K_DOT};
    return r;
  endfunction

  function automatic kind_t word_kind(input logic [LEN_W-1:0] n, input logic [63:0] w);
    kind_t k;
    k = K_IDENT;
    if (n == LEN_W'(3) && w == KW_U32)         k = K_U32;
    else if (n == LEN_W'(6) && w == KW_STRING) k = K_STRING;
    else if (n == LEN_W'(8) && w == KW_FUNC)   k = K_FUNC;
    else if (n == LEN_W'(2) && w == KW_IF)     k = K_IF;
    else if (n == LEN_W'(4) && w == KW_ELSE)   k = K_ELSE;
    else if (n == LEN_W'(3) && w == KW_VAR)    k = K_VAR;
    else if (n == LEN_W'(5) && w == KW_CONST)  k = K_CONST;
    else if (n == LEN_W'(6) && w == KW_RETURN) k = K_RETURN;
    return k;
  endfunction

  function automatic em_t mk(input kind_t k, input logic [31:0] l, input logic [31:0] c,
                             input logic [31:0] n);
    em_t e;
    e.vld  = 1'b1;
    e.kind = k;
    e.line = l;
    e.col  = c;
    e.len  = n;
    return e;
  endfunction

  function automatic st_t start_tok(input st_t s);
    st_t r;
    r        = s;
    r.tline  = s.line;
    r.tcol   = s.col;
    r.tlen   = '0;
    r.prefix = '0;
    return r;
  endfunction

  function automatic st_t grow(input st_t s, input logic [8:0] c);
    st_t r;
    r = s;
    if (s.tlen < LEN_W'(8)) r.prefix = {s.prefix[55:0], c[7:0]};
    if (s.tlen != '1) r.tlen = s.tlen + LEN_W'(1);
    return r;
  endfunction

  function automatic st_t advance(input st_t s, input logic [8:0] c);
    st_t r;
    r = s;
    if (c == C_NL) begin
      if (s.line != '1) r.line = s.line + POS_W'(1);
      r.col = POS_W'(1);
    end else if (s.col != '1) begin
      r.col = s.col + POS_W'(1);
    end
    return r;
  endfunction

  // Consume character p, deciding on the two characters that follow it
  function automatic cs_t consume(input st_t s, input logic [8:0] p, input logic [8:0] n1,
                                  input logic [8:0] n2);
    cs_t        r;
    logic [5:0] pk;
    logic       done;
    r.st = s;
    r.em = '0;
    done = 1'b0;
    pk   = punct(p, n1);
    if (s.phase == PH_IDLE) begin
      if (is_space(p)) begin
        done = 1'b1;
      end else if (p == C_SLASH && n1 == C_SLASH) begin
        r.st.phase = PH_LINE;
        done = 1'b1;
      end else if (p == C_SLASH && n1 == C_STAR) begin
        r.st.phase = PH_BOPEN;
        done = 1'b1;
      end else if (is_digit(p)) begin
        r.st = start_tok(s);
        r.st.phase = PH_INT;
      end else if (is_alpha(p) || p == C_USCORE) begin
        r.st = start_tok(s);
        r.st.phase = PH_IDENT;
      end else if (pk[4:0] == K_NONE) begin
        r.em = mk(K_ERROR, 32'(s.line), 32'(s.col), 32'd0);
        r.st.halted = 1'b1;
        return r;
      end else begin
        r.em = mk(pk[4:0], 32'(s.line), 32'(s.col), pk[5] ? 32'd2 : 32'd1);
        if (pk[5]) r.st.phase = PH_SKIP;
        done = 1'b1;
      end
    end
    if (!done) begin
      unique case (r.st.phase)
        PH_INT: begin
          r.st = grow(r.st, p);
          if (p == C_DOT) begin
            r.st.phase = PH_FRAC;
            if (!is_digit(n1)) begin
              r.em = mk(K_FLOAT, 32'(r.st.tline), 32'(r.st.tcol), 32'(r.st.tlen));
              r.st.phase = PH_IDLE;
            end
          end else if (!(is_digit(n1) || (n1 == C_DOT && is_digit(n2)))) begin
            r.em = mk(K_INT, 32'(r.st.tline), 32'(r.st.tcol), 32'(r.st.tlen));
            r.st.phase = PH_IDLE;
          end
        end
        PH_FRAC: begin
          r.st = grow(r.st, p);
          if (!is_digit(n1)) begin
            r.em = mk(K_FLOAT, 32'(r.st.tline), 32'(r.st.tcol), 32'(r.st.tlen));
            r.st.phase = PH_IDLE;
          end
        end
        PH_IDENT: begin
          r.st = grow(r.st, p);
          if (!is_word(n1)) begin
            r.em = mk(word_kind(r.st.tlen, r.st.prefix), 32'(r.st.tline),
                      32'(r.st.tcol), 32'(r.st.tlen));
            r.st.phase = PH_IDLE;
          end
        end
        PH_LINE:  if (p == C_NL) r.st.phase = PH_IDLE;
        PH_BOPEN: r.st.phase = PH_BLOCK;
        PH_BLOCK: if (p == C_STAR && n1 == C_SLASH) r.st.phase = PH_SKIP;
        default:  r.st.phase = PH_IDLE;
      endcase
    end
    r.st = advance(r.st, p);
    return r;
  endfunction

  st_t        st_r, st_nxt;
  logic [7:0] la0_r, la0_nxt, la1_r, la1_nxt;
  logic       la0v_r, la0v_nxt, la1v_r, la1v_nxt;

  st_t        st_rst;
  logic [8:0] c0, c1, nx;
  cs_t        cs_a, cs_b;
  st_t        st_a, st_b;
  em_t [2:0]  cand;
  logic [2:0] cvld;
  em_t        e_end;
  logic [1:0] res_n;

  always_comb begin
    st_rst        = '0;
    st_rst.phase  = PH_IDLE;
    st_rst.line   = POS_W'(1);
    st_rst.col    = POS_W'(1);

    c0 = la0v_r ? {1'b0, la0_r} : NO_CHAR;
    c1 = la1v_r ? {1'b0, la1_r} : NO_CHAR;
    nx = end_flag ? NO_CHAR : {1'b0, byte_in};

    // First consume; on the end marker the second one flushes the newer slot
    cs_a = consume(st_r, c0, c1, nx);
    st_a = la0v_r ? cs_a.st : st_r;
    cs_b = consume(st_a, c1, NO_CHAR, NO_CHAR);
    st_b = (la1v_r && !st_a.halted) ? cs_b.st : st_a;
    e_end = mk(K_END, 32'(st_b.line), 32'(st_b.col), 32'd0);

    cand[0] = cs_a.em;
    cand[1] = cs_b.em;
    cand[2] = e_end;
    cvld[0] = !st_r.halted && cs_a.em.vld && (end_flag ? la0v_r : la1v_r);
    cvld[1] = !st_r.halted && end_flag && la1v_r && !st_a.halted && cs_b.em.vld;
    cvld[2] = !st_r.halted && end_flag && !st_b.halted;

    push = '0;
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (cvld[i]) begin
        push.res[res_n].kind = cand[i].kind;
        push.res[res_n].line = sat16(cand[i].line);
        push.res[res_n].col  = sat16(cand[i].col);
        push.res[res_n].len  = sat16(cand[i].len);
        res_n = res_n + 2'd1;
      end
    end
    if (res_n != 2'd0) push.res[res_n - 2'd1].last = 1'b1;
    push.cnt = fire ? res_n : 2'd0;

    st_nxt   = st_r;
    la0_nxt  = la0_r;
    la1_nxt  = la1_r;
    la0v_nxt = la0v_r;
    la1v_nxt = la1v_r;
    if (fire && !st_r.halted) begin
      if (end_flag) begin
        if (st_b.halted) begin
          st_nxt = st_b;
        end else begin
          st_nxt   = st_rst;
          la0v_nxt = 1'b0;
          la1v_nxt = 1'b0;
        end
      end else if (la1v_r) begin
        st_nxt  = cs_a.st;
        la0_nxt = la1_r;
        la1_nxt = byte_in;
      end else if (la0v_r) begin
        la1_nxt  = byte_in;
        la1v_nxt = 1'b1;
      end else begin
        la0_nxt  = byte_in;
        la0v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= st_rst;
      la0v_r <= 1'b0;
      la1v_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      la0v_r <= la0v_nxt;
      la1v_r <= la1v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la0_r <= la0_nxt;
    la1_r <= la1_nxt;
  end

endmodule

`default_nettype wire

### sv/sl_outq.sv
`default_nettype none

module sl_outq import sl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_stall,
  output res_t       out_res
);

  res_t       mem [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Room for a whole transaction's worth of results
  assign room      = (cnt_r <= 3'd1);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem[rp_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(push.cnt)) mem[wp_r + 2'(i)] <= push.res[i];
    end
  end

endmodule

`default_nettype wire

### sv/source_lexer.sv
// Channel  | Direction | Ports                                        | Handshake
// ---------+-----------+----------------------------------------------+---------------
// in       | input     | in_byte_in, in_end_flag                      | valid / stall
// out      | output    | out_kind, out_start_line, out_start_col,     | valid / stall
//          |           | out_token_length, out_last                   |
//
// One transaction a cycle is taken while in_stall is low; its results pass through
// the input register, lookahead and result queue, behind results already queued.
// A character transaction gives at most one result; an end-marker transaction gives
// up to three, which leave a four-entry result queue one a cycle while out_stall is low.
// in_stall rises only while the input register holds a transaction and the queue
// has fewer than three free entries.
// rst_n is synchronous, active low: lookahead empty, line and column one, queue empty.
// After an error result the scanner takes and drops transactions until reset.
`default_nettype none

module source_lexer import sl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_end_flag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_kind,
  output logic [15:0]      out_start_line,
  output logic [15:0]      out_start_col,
  output logic [15:0]      out_token_length,
  output logic             out_last
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       room, fire, accept;
  push_t      push;
  res_t       res;

  // Advance the held transaction into the scanner when the queue can absorb it
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept)    in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload register: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte_in;
      in_end_r  <= in_end_flag;
    end
  end

  sl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .byte_in  (in_byte_r),
    .end_flag (in_end_r),
    .push     (push)
  );

  sl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_start_line   = res.line;
  assign out_start_col    = res.col;
  assign out_token_length = res.len;
  assign out_last         = res.last;

endmodule

`default_nettype wire

### sv/sl_checker.sv
`default_nettype none

module sl_checker import sl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte_in,
  input wire logic        in_end_flag,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  out_kind,
  input wire logic [15:0] out_start_line,
  input wire logic [15:0] out_start_col,
  input wire logic [15:0] out_token_length,
  input wire logic        out_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_token_length)
                               && $stable(out_start_line) && $stable(out_last))
    else $error("stalled result changed");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_ERROR |-> out_last && out_token_length == 16'd0)
    else $error("error result not final");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_END |-> out_last && out_token_length == 16'd0)
    else $error("end result not final");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_line != 16'd0 && out_start_col != 16'd0)
    else $error("result position zero");

endmodule

bind source_lexer sl_checker u_sl_checker (.*);

`default_nettype wire
